/* sv/rbro_pkg.sv */
// Shared types, constants and helpers for the rectangle blitter with raster combine.
// Used by rbro_regs and rect_blit_raster_op_unit; depends on nothing else.
package rbro_pkg;

	localparam int unsigned ADDR_W            = 32;
	localparam int unsigned WORD_W            = 32;
	localparam int unsigned COUNT_W           = 9;
	localparam int unsigned PADDR_W           = 5;
	localparam int unsigned PDATA_W           = 32;
	localparam int unsigned ROW_STRIDE_BYTES  = 160;
	localparam logic [ADDR_W-1:0] LONG_BYTES        = 32'd4;
	localparam logic [ADDR_W-1:0] CELL_STRIDE_BYTES = 32'd8;

	typedef enum logic [2:0] {
		REG_DEST_BASE     = 3'd0,
		REG_SOURCE_BASE   = 3'd1,
		REG_CELLS_PER_ROW = 3'd2,
		REG_ROWS_PER_BLIT = 3'd3,
		REG_COMBINE_OP    = 3'd4
	} rbro_reg_idx_t;

	typedef enum logic [1:0] {
		OP_COPY    = 2'd0,
		OP_OR      = 2'd1,
		OP_AND_NOT = 2'd2
	} rbro_op_t;

	typedef struct packed {
		logic [ADDR_W-1:0] dest_base;
		logic [ADDR_W-1:0] source_base;
		logic [7:0]        cells_per_row;
		logic [7:0]        rows_per_blit;
		logic [1:0]        combine_op;
	} rbro_cfg_t;

	// Register values as they stand after the current cycle, plus the rearm strobe.
	typedef struct packed {
		rbro_cfg_t cfg_d;
		logic      arm;
	} rbro_ctrl_t;

	// An 8-bit count register where zero stands for 256.
	function automatic logic [COUNT_W-1:0] count_of(input logic [7:0] v);
		count_of = {(v == 8'd0), v};
	endfunction

endpackage

/* sv/rect_blit_raster_op_unit.sv */
// Top level of the rectangle blitter with raster combine: address walk, combine, output word.
// Depends on rbro_pkg and rbro_regs.
//
// The blitter takes one input word per clock: each word carries the source longword and the
// old destination longword at the current position, and yields one output word with the
// write address, the combined longword, the addresses of the next pair to fetch and a last
// flag. The address walk and the combine are combinational between the walk registers and
// a single output register, so a result is out the cycle after its word is taken, and a new
// word is taken every cycle while the output register is empty or being drained. A write to
// a defined register rearms the walk from the registers; the word flagged last rearms it too.
module rect_blit_raster_op_unit #(
	parameter int unsigned ROW_STRIDE_BYTES = rbro_pkg::ROW_STRIDE_BYTES
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// Configuration port.
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [rbro_pkg::PADDR_W-1:0] paddr,
	input  logic [rbro_pkg::PDATA_W-1:0] pwdata,
	output logic [rbro_pkg::PDATA_W-1:0] prdata,
	output logic                         pready,
	// Input stream.
	input  logic                         s_axis_tvalid,
	output logic                         s_axis_tready,
	input  logic [63:0]                  s_axis_tdata,  // source_word, old_dest_word
	// Output stream.
	output logic                         m_axis_tvalid,
	input  logic                         m_axis_tready,
	// write_address, write_word, next_source_address, next_dest_address
	output logic [127:0]                 m_axis_tdata,
	output logic                         m_axis_tlast   // is_last
);

	localparam logic [rbro_pkg::ADDR_W-1:0] ROW_STRIDE = rbro_pkg::ADDR_W'(ROW_STRIDE_BYTES);

	rbro_pkg::rbro_cfg_t  cfg;
	rbro_pkg::rbro_ctrl_t ctrl;

	logic [rbro_pkg::COUNT_W-1:0] cells_left_q, cells_left_d, cells_dec;
	logic [rbro_pkg::COUNT_W-1:0] rows_left_q, rows_left_d, rows_dec;
	logic                         half_q, half_d;
	logic [rbro_pkg::ADDR_W-1:0]  src_ptr_q, src_ptr_d;
	logic [rbro_pkg::ADDR_W-1:0]  row_start_q, row_start_d, row_next;
	logic [rbro_pkg::ADDR_W-1:0]  dest_ptr_q, dest_ptr_d;
	logic [rbro_pkg::WORD_W-1:0]  src_word, old_word, comb_word;
	logic                         last;
	logic                         accept;

	logic                         out_valid_q;
	logic [127:0]                 out_data_q;
	logic                         out_last_q;

	rbro_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg),
		.ctrl    (ctrl)
	);

	assign src_word      = s_axis_tdata[31:0];
	assign old_word      = s_axis_tdata[63:32];
	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign accept        = s_axis_tvalid && s_axis_tready;

	always_comb begin
		case (rbro_pkg::rbro_op_t'(cfg.combine_op))
			rbro_pkg::OP_OR:      comb_word = src_word | old_word;
			rbro_pkg::OP_AND_NOT: comb_word = old_word & ~src_word;
			default:              comb_word = src_word;
		endcase
	end

	// Address walk for the accepted word. Both halves of a cell step the destination by
	// one longword; only a row or rectangle end departs from that.
	assign cells_dec = cells_left_q - 1'b1;
	assign rows_dec  = rows_left_q - 1'b1;
	assign row_next  = row_start_q + ROW_STRIDE;

	always_comb begin
		cells_left_d = cells_left_q;
		rows_left_d  = rows_left_q;
		half_d       = !half_q;
		src_ptr_d    = src_ptr_q + rbro_pkg::LONG_BYTES;
		row_start_d  = row_start_q;
		dest_ptr_d   = half_q ? dest_ptr_q - rbro_pkg::LONG_BYTES + rbro_pkg::CELL_STRIDE_BYTES
		                      : dest_ptr_q + rbro_pkg::LONG_BYTES;
		last         = 1'b0;
		if (half_q) begin
			cells_left_d = cells_dec;
			if (cells_dec == '0) begin
				rows_left_d = rows_dec;
				if (rows_dec == '0) begin
					last         = 1'b1;
					cells_left_d = rbro_pkg::count_of(cfg.cells_per_row);
					rows_left_d  = rbro_pkg::count_of(cfg.rows_per_blit);
					half_d       = 1'b0;
					src_ptr_d    = cfg.source_base;
					row_start_d  = cfg.dest_base;
					dest_ptr_d   = cfg.dest_base;
				end else begin
					row_start_d  = row_next;
					dest_ptr_d   = row_next;
					cells_left_d = rbro_pkg::count_of(cfg.cells_per_row);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cells_left_q <= rbro_pkg::count_of(8'd0);
			rows_left_q  <= rbro_pkg::count_of(8'd0);
			half_q       <= 1'b0;
			src_ptr_q    <= '0;
			row_start_q  <= '0;
			dest_ptr_q   <= '0;
		end else if (ctrl.arm) begin
			cells_left_q <= rbro_pkg::count_of(ctrl.cfg_d.cells_per_row);
			rows_left_q  <= rbro_pkg::count_of(ctrl.cfg_d.rows_per_blit);
			half_q       <= 1'b0;
			src_ptr_q    <= ctrl.cfg_d.source_base;
			row_start_q  <= ctrl.cfg_d.dest_base;
			dest_ptr_q   <= ctrl.cfg_d.dest_base;
		end else if (accept) begin
			cells_left_q <= cells_left_d;
			rows_left_q  <= rows_left_d;
			half_q       <= half_d;
			src_ptr_q    <= src_ptr_d;
			row_start_q  <= row_start_d;
			dest_ptr_q   <= dest_ptr_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_data_q <= {dest_ptr_d, src_ptr_d, comb_word, dest_ptr_q};
			out_last_q <= last;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tlast  = out_last_q;

endmodule

/* sv/rbro_regs.sv */
// APB-style configuration registers of the rectangle blitter.
// Depends on rbro_pkg; feeds the current and next register values to the top level.
module rbro_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [rbro_pkg::PADDR_W-1:0]  paddr,
	input  logic [rbro_pkg::PDATA_W-1:0]  pwdata,
	output logic [rbro_pkg::PDATA_W-1:0]  prdata,
	output logic                          pready,
	output rbro_pkg::rbro_cfg_t           cfg,
	output rbro_pkg::rbro_ctrl_t          ctrl
);

	rbro_pkg::rbro_cfg_t     cfg_q;
	rbro_pkg::rbro_cfg_t     cfg_d;
	rbro_pkg::rbro_reg_idx_t idx;
	logic                    wr_en;
	logic                    hit;

	assign pready = 1'b1;
	assign idx    = rbro_pkg::rbro_reg_idx_t'(paddr[4:2]);
	assign wr_en  = psel && penable && pwrite && pready;

	always_comb begin
		cfg_d = cfg_q;
		hit   = 1'b0;
		if (wr_en) begin
			case (idx)
				rbro_pkg::REG_DEST_BASE: begin
					cfg_d.dest_base = pwdata;
					hit = 1'b1;
				end
				rbro_pkg::REG_SOURCE_BASE: begin
					cfg_d.source_base = pwdata;
					hit = 1'b1;
				end
				rbro_pkg::REG_CELLS_PER_ROW: begin
					cfg_d.cells_per_row = pwdata[7:0];
					hit = 1'b1;
				end
				rbro_pkg::REG_ROWS_PER_BLIT: begin
					cfg_d.rows_per_blit = pwdata[7:0];
					hit = 1'b1;
				end
				rbro_pkg::REG_COMBINE_OP: begin
					cfg_d.combine_op = pwdata[1:0];
					hit = 1'b1;
				end
				default: begin
					hit = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else begin
			cfg_q <= cfg_d;
		end
	end

	always_comb begin
		case (idx)
			rbro_pkg::REG_DEST_BASE:     prdata = cfg_q.dest_base;
			rbro_pkg::REG_SOURCE_BASE:   prdata = cfg_q.source_base;
			rbro_pkg::REG_CELLS_PER_ROW: prdata = {24'd0, cfg_q.cells_per_row};
			rbro_pkg::REG_ROWS_PER_BLIT: prdata = {24'd0, cfg_q.rows_per_blit};
			rbro_pkg::REG_COMBINE_OP:    prdata = {30'd0, cfg_q.combine_op};
			default:                     prdata = '0;
		endcase
	end

	assign cfg        = cfg_q;
	assign ctrl.cfg_d = cfg_d;
	assign ctrl.arm   = hit;

endmodule

/* tb/sv/tb_rect_blit_raster_op_unit.sv */
`timescale 1ns / 100ps
// Self-checking testbench for rect_blit_raster_op_unit: an in-bench model of the rectangle walk
// and raster combine predicts every output word. Depends on rbro_pkg and the unit itself.
module tb_rect_blit_raster_op_unit;

	localparam int          ITEM_GOAL      = 1900;
	localparam int          HOLD_CYCLES    = 300;
	localparam int          SETTLE_CYCLES  = 4;
	localparam logic [1:0]  OP_UNUSED      = 2'd3;
	localparam logic [2:0]  REG_LAST_INDEX = 3'd7;

	typedef struct packed {
		logic [rbro_pkg::ADDR_W-1:0] write_address;
		logic [rbro_pkg::WORD_W-1:0] write_word;
		logic [rbro_pkg::ADDR_W-1:0] next_source;
		logic [rbro_pkg::ADDR_W-1:0] next_dest;
		logic                        is_last;
	} blit_result_t;

	typedef enum {RX_OPEN, RX_HALF, RX_LIGHT, RX_HEAVY} rx_mode_t;

	logic                           clk           = 1'b0;
	logic                           arst_n        = 1'b0;
	logic                           psel          = 1'b0;
	logic                           penable       = 1'b0;
	logic                           pwrite        = 1'b0;
	logic [rbro_pkg::PADDR_W-1:0]   paddr         = '0;
	logic [rbro_pkg::PDATA_W-1:0]   pwdata        = '0;
	logic [rbro_pkg::PDATA_W-1:0]   prdata;
	logic                           pready;
	logic                           s_axis_tvalid = 1'b0;
	logic                           s_axis_tready;
	logic [63:0]                    s_axis_tdata  = '0;  // source_word, old_dest_word
	logic                           m_axis_tvalid;
	logic                           m_axis_tready = 1'b0;
	// write_address, write_word, next_source_address, next_dest_address
	logic [127:0]                   m_axis_tdata;
	logic                           m_axis_tlast;       // is_last

	// Blit model: registers and walk state.
	rbro_pkg::rbro_cfg_t            cfg;
	logic [rbro_pkg::COUNT_W-1:0]   cells_left;
	logic [rbro_pkg::COUNT_W-1:0]   rows_left;
	logic                           half_sel;
	logic [rbro_pkg::ADDR_W-1:0]    src_ptr;
	logic [rbro_pkg::ADDR_W-1:0]    row_start;
	logic [rbro_pkg::ADDR_W-1:0]    dst_ptr;

	logic [63:0]          pair_q[$];
	blit_result_t         blit_q[$];
	int                   pairs_offered = 0;
	int                   mismatches    = 0;
	logic                 in_took       = 1'b0;
	int                   burst_left    = 0;
	int                   gap_left      = 0;
	int                   hold_left     = 0;
	logic                 held_once     = 1'b0;
	rx_mode_t             rx_mode       = RX_OPEN;
	int                   rx_left       = 0;

	rect_blit_raster_op_unit u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	always #5 clk = ~clk;

	function automatic logic [rbro_pkg::COUNT_W-1:0] span(input logic [7:0] v);
		return (v == 8'd0) ? 9'd256 : {1'b0, v};
	endfunction

	function automatic void rearm();
		cells_left = span(cfg.cells_per_row);
		rows_left  = span(cfg.rows_per_blit);
		half_sel   = 1'b0;
		src_ptr    = cfg.source_base;
		row_start  = cfg.dest_base;
		dst_ptr    = cfg.dest_base;
	endfunction

	// Returns the value the register keeps; unused indexes leave the walk alone.
	function automatic logic [31:0] cfg_store(input logic [2:0] idx, input logic [31:0] v);
		logic [31:0] kept;
		case (idx)
			rbro_pkg::REG_DEST_BASE: begin
				cfg.dest_base = v;
				kept = v;
			end
			rbro_pkg::REG_SOURCE_BASE: begin
				cfg.source_base = v;
				kept = v;
			end
			rbro_pkg::REG_CELLS_PER_ROW: begin
				cfg.cells_per_row = v[7:0];
				kept = {24'h0, v[7:0]};
			end
			rbro_pkg::REG_ROWS_PER_BLIT: begin
				cfg.rows_per_blit = v[7:0];
				kept = {24'h0, v[7:0]};
			end
			rbro_pkg::REG_COMBINE_OP: begin
				cfg.combine_op = v[1:0];
				kept = {30'h0, v[1:0]};
			end
			default: return 32'h0;
		endcase
		rearm();
		return kept;
	endfunction

	function automatic blit_result_t blit_step(input logic [31:0] src, input logic [31:0] old);
		blit_result_t r;
		r.write_address = dst_ptr;
		if (cfg.combine_op == rbro_pkg::OP_OR)
			r.write_word = src | old;
		else if (cfg.combine_op == rbro_pkg::OP_AND_NOT)
			r.write_word = old & ~src;
		else
			r.write_word = src;
		r.is_last = 1'b0;
		src_ptr = src_ptr + rbro_pkg::LONG_BYTES;
		if (!half_sel) begin
			half_sel = 1'b1;
			dst_ptr  = dst_ptr + rbro_pkg::LONG_BYTES;
		end else begin
			half_sel   = 1'b0;
			dst_ptr    = dst_ptr - rbro_pkg::LONG_BYTES + rbro_pkg::CELL_STRIDE_BYTES;
			cells_left = cells_left - 1'b1;
			if (cells_left == '0) begin
				rows_left = rows_left - 1'b1;
				if (rows_left == '0) begin
					r.is_last = 1'b1;
					rearm();
				end else begin
					row_start  = row_start + 32'(rbro_pkg::ROW_STRIDE_BYTES);
					dst_ptr    = row_start;
					cells_left = span(cfg.cells_per_row);
				end
			end
		end
		r.next_source = src_ptr;
		r.next_dest   = dst_ptr;
		return r;
	endfunction

	function automatic void flag(input string what, input logic [31:0] exp_v,
			input logic [31:0] act_v);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t: %s mismatch: expected %h, got %h", $time, what, exp_v, act_v);
	endfunction

	function automatic logic [31:0] rand_word();
		case ($urandom_range(0, 7))
			0: return 32'h0000_0000;
			1: return 32'hFFFF_FFFF;
			default: return $urandom();
		endcase
	endfunction

	function automatic logic [31:0] rand_addr();
		if ($urandom_range(0, 3) == 0)
			return 32'hFFFF_FF00 | $urandom_range(0, 255);
		return $urandom();
	endfunction

	function automatic void offer(input logic [31:0] src, input logic [31:0] old);
		pair_q.push_back({old, src});
		pairs_offered++;
	endfunction

	// Waits until nothing is queued, offered or outstanding.
	task automatic wait_idle();
		while (pair_q.size() != 0 || s_axis_tvalid || blit_q.size() != 0)
			@(negedge clk);
	endtask

	task automatic reg_write(input logic [2:0] idx, input logic [31:0] value);
		logic [31:0] kept;
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		kept = cfg_store(idx, value);
		@(negedge clk);
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (idx <= rbro_pkg::REG_COMBINE_OP && prdata !== kept)
			flag("register read-back", kept, prdata);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// Sender: bursts of words with random gaps; a word stays put until it is taken.
	always @(negedge clk) begin
		if (s_axis_tvalid && !in_took) begin
		end else if (gap_left > 0) begin
			gap_left = gap_left - 1;
			s_axis_tvalid <= 1'b0;
		end else if (pair_q.size() != 0) begin
			s_axis_tdata  <= pair_q.pop_front();
			s_axis_tvalid <= 1'b1;
			burst_left = burst_left - 1;
			if (burst_left <= 0) begin
				burst_left = $urandom_range(1, 48);
				gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			end
		end else begin
			s_axis_tvalid <= 1'b0;
		end
	end

	// Receiver: stall patterns that change every so often, and one long hold-off once a
	// large backlog is waiting so that the unit fills up and stalls its input.
	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left = hold_left - 1;
			m_axis_tready <= 1'b0;
		end else if (!held_once && pair_q.size() > 100) begin
			held_once = 1'b1;
			hold_left = HOLD_CYCLES;
			m_axis_tready <= 1'b0;
		end else begin
			if (rx_left == 0) begin
				rx_mode = rx_mode_t'($urandom_range(0, 3));
				rx_left = $urandom_range(20, 200);
			end
			rx_left = rx_left - 1;
			case (rx_mode)
				RX_OPEN:  m_axis_tready <= 1'b1;
				RX_HALF:  m_axis_tready <= $urandom_range(0, 1);
				RX_LIGHT: m_axis_tready <= ($urandom_range(0, 7) != 0);
				default:  m_axis_tready <= ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	// Checks each output word against the oldest prediction, then predicts for any word
	// taken on the input at the same edge.
	always @(posedge clk) begin : monitor
		blit_result_t exp_r;
		blit_result_t act_r;
		if (m_axis_tvalid && m_axis_tready) begin
			act_r.write_address = m_axis_tdata[31:0];
			act_r.write_word    = m_axis_tdata[63:32];
			act_r.next_source   = m_axis_tdata[95:64];
			act_r.next_dest     = m_axis_tdata[127:96];
			act_r.is_last       = m_axis_tlast;
			if (blit_q.size() == 0) begin
				flag("word with nothing expected, write_address", 32'h0, act_r.write_address);
			end else begin
				exp_r = blit_q.pop_front();
				if (act_r.write_address !== exp_r.write_address)
					flag("write_address", exp_r.write_address, act_r.write_address);
				if (act_r.write_word !== exp_r.write_word)
					flag("write_word", exp_r.write_word, act_r.write_word);
				if (act_r.next_source !== exp_r.next_source)
					flag("next_source_address", exp_r.next_source, act_r.next_source);
				if (act_r.next_dest !== exp_r.next_dest)
					flag("next_dest_address", exp_r.next_dest, act_r.next_dest);
				if (act_r.is_last !== exp_r.is_last)
					flag("is_last", 32'(exp_r.is_last), 32'(act_r.is_last));
			end
		end
		if (s_axis_tvalid && s_axis_tready)
			blit_q.push_back(blit_step(s_axis_tdata[31:0], s_axis_tdata[63:32]));
		in_took <= s_axis_tvalid && s_axis_tready;
	end

	initial begin : stimulus
		int          phase;
		int          n;
		int          len;
		logic        extreme;
		logic [7:0]  cells;
		logic [7:0]  rows;
		cfg = '0;
		rearm();
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;

		// Straight out of reset a 256 by 256 copy from address zero is armed.
		@(posedge clk);
		offer(32'h0000_0000, 32'h0000_0000);
		offer(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		offer(32'hA5A5_A5A5, 32'h5A5A_5A5A);
		offer(32'h0000_0000, 32'hFFFF_FFFF);
		wait_idle();

		// A 2 by 2 OR blit near the top of the address space, so that both walks wrap;
		// the extra words run on into the blit that rearms after the last word.
		reg_write(rbro_pkg::REG_DEST_BASE, 32'hFFFF_FFF0);
		reg_write(rbro_pkg::REG_SOURCE_BASE, 32'hFFFF_FFF8);
		reg_write(rbro_pkg::REG_CELLS_PER_ROW, 32'd2);
		reg_write(rbro_pkg::REG_ROWS_PER_BLIT, 32'd2);
		reg_write(rbro_pkg::REG_COMBINE_OP, 32'(rbro_pkg::OP_OR));
		@(posedge clk);
		offer(32'h0000_0000, 32'h0000_0000);
		offer(32'h0000_0000, 32'hFFFF_FFFF);
		offer(32'hFFFF_FFFF, 32'h0000_0000);
		offer(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		for (int i = 0; i < 6; i++)
			offer($urandom(), $urandom());
		wait_idle();

		reg_write(rbro_pkg::REG_COMBINE_OP, 32'(rbro_pkg::OP_AND_NOT));
		@(posedge clk);
		offer(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		offer(32'h0000_0000, 32'hFFFF_FFFF);
		offer(32'hF0F0_F0F0, 32'hFFFF_0000);
		offer(32'hFFFF_FFFF, 32'h0000_0000);
		wait_idle();

		// The spare combine code copies; a write to an unused index must not rearm the walk.
		reg_write(rbro_pkg::REG_COMBINE_OP, 32'(OP_UNUSED));
		@(posedge clk);
		offer(32'h1234_5678, 32'hFFFF_FFFF);
		offer(32'h8765_4321, 32'h0000_0000);
		wait_idle();
		reg_write(REG_LAST_INDEX, 32'hFFFF_FFFF);
		@(posedge clk);
		offer(32'hDEAD_BEEF, 32'h0F0F_0F0F);
		offer(32'h0000_0000, 32'hFFFF_FFFF);
		offer(32'hFFFF_FFFF, 32'h0000_0000);
		wait_idle();

		for (phase = 0; pairs_offered < ITEM_GOAL; phase++) begin
			if (phase != 0 && $urandom_range(0, 7) == 0) begin
				reg_write(REG_LAST_INDEX - 3'($urandom_range(0, 2)), $urandom());
				n = $urandom_range(1, 20);
			end else begin
				// The first phase is always a long one, which gives the hold-off its backlog.
				extreme = (phase == 0) || ($urandom_range(0, 19) == 0);
				if (extreme) begin
					case ((phase == 0) ? 0 : $urandom_range(0, 3))
						0: begin
							cells = 8'd0;
							rows  = 8'd1;
						end
						1: begin
							cells = 8'd1;
							rows  = 8'd0;
						end
						2: begin
							cells = 8'd255;
							rows  = 8'd1;
						end
						default: begin
							cells = 8'd1;
							rows  = 8'd255;
						end
					endcase
				end else begin
					cells = $urandom_range(1, 6);
					rows  = $urandom_range(1, 4);
				end
				if ($urandom_range(0, 1) != 0)
					reg_write(rbro_pkg::REG_DEST_BASE, rand_addr());
				reg_write(rbro_pkg::REG_CELLS_PER_ROW, {24'h0, cells});
				if ($urandom_range(0, 1) != 0)
					reg_write(rbro_pkg::REG_SOURCE_BASE, rand_addr());
				reg_write(rbro_pkg::REG_ROWS_PER_BLIT, {24'h0, rows});
				if ($urandom_range(0, 1) != 0)
					reg_write(rbro_pkg::REG_COMBINE_OP, $urandom_range(0, 3));
				len = 2 * int'(span(cfg.cells_per_row)) * int'(span(cfg.rows_per_blit));
				if (extreme)
					n = len + $urandom_range(0, 2);
				else if ($urandom_range(0, 4) == 0)
					n = $urandom_range(1, len);
				else
					n = len * $urandom_range(1, 2) + $urandom_range(0, 3);
			end
			@(posedge clk);
			repeat (n) offer(rand_word(), rand_word());
			wait_idle();
		end

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0 && blit_q.size() == 0) begin
			$display("rect_blit_raster_op_unit verification clean");
		end else begin
			$display("rect_blit_raster_op_unit verification failed");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("rect_blit_raster_op_unit verification failed");
		$finish;
	end

endmodule
